FILE: design/fcr_pkg.sv
// fcr_pkg: widths, limits, reset values and register indexes of the feedback comb reverb
// used by feedback_comb_reverb_top; depends on nothing else
package fcr_pkg;

   // sample and store formats
   localparam int SAMPLE_W = 16;              // signed pcm sample
   localparam int STORE_W = 22;               // signed q.4 store entry
   localparam int Y5_W = 23;                  // signed q.5 sum x*32 + entry
   localparam int OUT_SHIFT = 5;              // q.5 to integer sample
   localparam int GAIN_W = 16;                // unsigned q1.15 damping
   localparam int FRAC_SHIFT = 16;            // product scale back to q.4
   localparam int PROD_W = Y5_W + GAIN_W + 1; // signed product width

   // delay line geometry
   localparam int MAX_DELAY_FRAMES = 8192;
   localparam int MAX_CHANNELS = 2;
   localparam int SLOT_W = $clog2(MAX_DELAY_FRAMES);
   localparam int CHAN_W = $clog2(MAX_CHANNELS);
   localparam int ADDR_W = SLOT_W + CHAN_W;
   localparam int STORE_DEPTH = MAX_DELAY_FRAMES * MAX_CHANNELS;

   // control registers
   localparam int DELAY_W = 14;
   localparam int CHCNT_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_FRAMES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(1);
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(16384);
   localparam logic [CHCNT_W-1:0] CHCNT_RESET = CHCNT_W'(1);

   localparam logic [DELAY_W-1:0] DELAY_MAX = DELAY_W'(MAX_DELAY_FRAMES);
   localparam logic [CHCNT_W-1:0] CHCNT_MAX = CHCNT_W'(MAX_CHANNELS);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic signed [STORE_W-1:0] entry_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

FILE: design/feedback_comb_reverb_top.sv
// feedback_comb_reverb_top: feedback comb filter over an interleaved pcm request stream
// uses fcr_pkg for formats, delay line geometry and register indexes
//
// latency: an accepted request is registered into s1, which pushes its response to the queue
// throughput: one request per cycle while the response queue has room, set by the one read
//   and one write port of the delay store; when delay_frames times channel_count is one, the
//   same entry comes back every request and a request waits while the last is still in s1
// reset: synchronous, active high; afterwards all 16384 delay store entries are cleared one
//   entry per cycle, during which req_ready stays low (csr writes still taken)

module feedback_comb_reverb_top (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [fcr_pkg::SAMPLE_W-1:0] req_sample_in,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [fcr_pkg::SAMPLE_W-1:0] rsp_sample_out,
   // control register write port
   input  logic                                csr_we,
   input  logic [fcr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fcr_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int WB_W = fcr_pkg::PROD_W - fcr_pkg::FRAC_SHIFT;
   localparam int O_W = fcr_pkg::Y5_W - fcr_pkg::OUT_SHIFT;
   localparam logic [fcr_pkg::PROD_W-1:0] PROD_BIAS =
      fcr_pkg::PROD_W'((64'd1 << fcr_pkg::FRAC_SHIFT) - 64'd1);
   localparam logic [fcr_pkg::Y5_W-1:0] Y5_BIAS =
      fcr_pkg::Y5_W'((64'd1 << fcr_pkg::OUT_SHIFT) - 64'd1);

   // ---------------------------------------------------------------------------------
   // control registers
   // ---------------------------------------------------------------------------------
   logic [fcr_pkg::DELAY_W-1:0] delay_frames_ff;
   logic [fcr_pkg::GAIN_W-1:0]  damping_gain_ff;
   logic [fcr_pkg::CHCNT_W-1:0] channel_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_frames_ff  <= fcr_pkg::DELAY_RESET;
         damping_gain_ff  <= fcr_pkg::GAIN_RESET;
         channel_count_ff <= fcr_pkg::CHCNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            fcr_pkg::CSR_DELAY_FRAMES:  delay_frames_ff  <= csr_wdata[fcr_pkg::DELAY_W-1:0];
            fcr_pkg::CSR_DAMPING_GAIN:  damping_gain_ff  <= csr_wdata[fcr_pkg::GAIN_W-1:0];
            fcr_pkg::CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[fcr_pkg::CHCNT_W-1:0];
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   // effective lengths: zero means one, anything above the store size saturates
   logic [fcr_pkg::DELAY_W-1:0] eff_delay;
   logic [fcr_pkg::CHCNT_W-1:0] eff_chans;

   always_comb begin
      if (delay_frames_ff == '0)                  eff_delay = fcr_pkg::DELAY_W'(1);
      else if (delay_frames_ff > fcr_pkg::DELAY_MAX) eff_delay = fcr_pkg::DELAY_MAX;
      else                                        eff_delay = delay_frames_ff;
   end

   always_comb begin
      if (channel_count_ff == '0)                    eff_chans = fcr_pkg::CHCNT_RESET;
      else if (channel_count_ff > fcr_pkg::CHCNT_MAX) eff_chans = fcr_pkg::CHCNT_MAX;
      else                                           eff_chans = channel_count_ff;
   end

   // ---------------------------------------------------------------------------------
   // store clearing pass after reset
   // ---------------------------------------------------------------------------------
   logic                 clr_busy_ff, clr_busy_in;
   fcr_pkg::addr_type    clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + fcr_pkg::ADDR_W'(1);
         if (clr_addr_ff == fcr_pkg::ADDR_W'(fcr_pkg::STORE_DEPTH - 1)) clr_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // frame slot and channel position
   // ---------------------------------------------------------------------------------
   logic [fcr_pkg::SLOT_W-1:0] frame_slot_ff, frame_slot_in;
   logic [fcr_pkg::CHAN_W-1:0] channel_pos_ff, channel_pos_in;
   fcr_pkg::addr_type          cur_addr;
   logic                       req_fire;

   assign cur_addr = {frame_slot_ff, channel_pos_ff};
   assign req_fire = req_valid & req_ready;

   always_comb begin
      frame_slot_in  = frame_slot_ff;
      channel_pos_in = channel_pos_ff;
      if (req_fire) begin
         if (({1'b0, channel_pos_ff} + (fcr_pkg::CHAN_W + 1)'(1)) >=
             (fcr_pkg::CHAN_W + 1)'(eff_chans)) begin
            // last channel of the frame: step the slot, wrap at the delay length
            channel_pos_in = '0;
            if (({1'b0, frame_slot_ff} + (fcr_pkg::SLOT_W + 1)'(1)) >=
                (fcr_pkg::SLOT_W + 1)'(eff_delay))
               frame_slot_in = '0;
            else
               frame_slot_in = frame_slot_ff + fcr_pkg::SLOT_W'(1);
         end else begin
            channel_pos_in = channel_pos_ff + fcr_pkg::CHAN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_slot_ff  <= '0;
         channel_pos_ff <= '0;
      end else begin
         frame_slot_ff  <= frame_slot_in;
         channel_pos_ff <= channel_pos_in;
      end
   end

   // ---------------------------------------------------------------------------------
   // pipeline registers
   //   s1: store read data back, sum formed, response pushed
   //   s2: multiply by damping
   //   s3: scale, saturate, write back
   // ---------------------------------------------------------------------------------
   logic                          s1_valid_ff, s2_valid_ff, s3_valid_ff, lw_valid_ff;
   fcr_pkg::addr_type             s1_addr_ff, s2_addr_ff, s3_addr_ff, lw_addr_ff;
   fcr_pkg::sample_type           s1_x_ff;
   logic signed [fcr_pkg::Y5_W-1:0]   s2_y5_ff, s2_y5_in;
   logic signed [fcr_pkg::PROD_W-1:0] s3_prod_ff, s3_prod_in;
   fcr_pkg::entry_type            lw_data_ff;
   fcr_pkg::entry_type            rd_data_ff;
   fcr_pkg::entry_type            wb_data;

   // ---------------------------------------------------------------------------------
   // delay store: one write port, one registered read port
   // ---------------------------------------------------------------------------------
   fcr_pkg::entry_type store_mem [fcr_pkg::STORE_DEPTH];
   logic               mem_we;
   fcr_pkg::addr_type  mem_waddr;
   fcr_pkg::entry_type mem_wdata;

   always_comb begin
      if (clr_busy_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = s3_valid_ff;
         mem_waddr = s3_addr_ff;
         mem_wdata = wb_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_waddr] <= mem_wdata;
   end

   // read every cycle at the current position; only used when a request went in
   always_ff @(posedge clock) begin
      rd_data_ff <= store_mem[cur_addr];
   end

   // ---------------------------------------------------------------------------------
   // s1: pick the freshest value of the entry, form y5 = x*32 + entry
   // ---------------------------------------------------------------------------------
   fcr_pkg::entry_type              entry;
   logic signed [fcr_pkg::Y5_W-1:0] x_scaled;
   logic [fcr_pkg::Y5_W-1:0]        y5_adj;
   logic [O_W-1:0]                  o_wide;
   fcr_pkg::sample_type             s1_out;

   always_comb begin
      // the request two ahead writes this cycle, the one three ahead wrote last cycle
      // and was missed by the read; one ahead cannot match (held off at the input)
      if (s3_valid_ff && s3_addr_ff == s1_addr_ff)      entry = wb_data;
      else if (lw_valid_ff && lw_addr_ff == s1_addr_ff) entry = lw_data_ff;
      else                                              entry = rd_data_ff;
   end

   assign x_scaled =
      {{(fcr_pkg::Y5_W - fcr_pkg::SAMPLE_W - fcr_pkg::OUT_SHIFT){s1_x_ff[fcr_pkg::SAMPLE_W-1]}},
       s1_x_ff, fcr_pkg::OUT_SHIFT'(0)};
   assign s2_y5_in = x_scaled + {entry[fcr_pkg::STORE_W-1], entry};

   // response: y5 / 32 toward zero, clamped to the sample range
   always_comb begin
      y5_adj = s2_y5_in[fcr_pkg::Y5_W-1] ? (s2_y5_in + Y5_BIAS) : s2_y5_in;
      o_wide = y5_adj[fcr_pkg::Y5_W-1:fcr_pkg::OUT_SHIFT];
      if ((&o_wide[O_W-1:fcr_pkg::SAMPLE_W-1]) || !(|o_wide[O_W-1:fcr_pkg::SAMPLE_W-1]))
         s1_out = o_wide[fcr_pkg::SAMPLE_W-1:0];
      else if (o_wide[O_W-1])
         s1_out = {1'b1, {(fcr_pkg::SAMPLE_W - 1){1'b0}}};
      else
         s1_out = {1'b0, {(fcr_pkg::SAMPLE_W - 1){1'b1}}};
   end

   // ---------------------------------------------------------------------------------
   // s2: damping multiply
   // ---------------------------------------------------------------------------------
   logic signed [fcr_pkg::GAIN_W:0] gain_s;

   assign gain_s     = {1'b0, damping_gain_ff};
   assign s3_prod_in = s2_y5_ff * gain_s;

   // ---------------------------------------------------------------------------------
   // s3: product / 65536 toward zero, saturated to the store range
   // ---------------------------------------------------------------------------------
   logic [fcr_pkg::PROD_W-1:0] prod_adj;
   logic [WB_W-1:0]            wb_wide;

   always_comb begin
      prod_adj = s3_prod_ff[fcr_pkg::PROD_W-1] ? (s3_prod_ff + PROD_BIAS) : s3_prod_ff;
      wb_wide  = prod_adj[fcr_pkg::PROD_W-1:fcr_pkg::FRAC_SHIFT];
      if ((&wb_wide[WB_W-1:fcr_pkg::STORE_W-1]) || !(|wb_wide[WB_W-1:fcr_pkg::STORE_W-1]))
         wb_data = wb_wide[fcr_pkg::STORE_W-1:0];
      else if (wb_wide[WB_W-1])
         wb_data = {1'b1, {(fcr_pkg::STORE_W - 1){1'b0}}};
      else
         wb_data = {1'b0, {(fcr_pkg::STORE_W - 1){1'b1}}};
   end

   // pipeline advance: the write-back side never stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         lw_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= cur_addr;
      s1_x_ff    <= req_sample_in;
      s2_addr_ff <= s1_addr_ff;
      s2_y5_ff   <= s2_y5_in;
      s3_addr_ff <= s2_addr_ff;
      s3_prod_ff <= s3_prod_in;
      lw_addr_ff <= s3_addr_ff;
      lw_data_ff <= wb_data;
   end

   // ---------------------------------------------------------------------------------
   // response queue, two entries; head drives the response port
   // ---------------------------------------------------------------------------------
   fcr_pkg::sample_type q_ff [2];
   fcr_pkg::sample_type q_in [2];
   logic [1:0]          count_ff, count_in;
   logic                rsp_pop;
   logic [1:0]          count_after_pop;

   assign rsp_valid      = (count_ff != 2'd0);
   assign rsp_sample_out = q_ff[0];
   assign rsp_pop        = rsp_valid & rsp_ready;

   always_comb begin
      q_in[0]         = q_ff[0];
      q_in[1]         = q_ff[1];
      count_after_pop = count_ff;
      if (rsp_pop) begin
         q_in[0]         = q_ff[1];
         count_after_pop = count_ff - 2'd1;
      end
      count_in = count_after_pop;
      if (s1_valid_ff) begin
         if (count_after_pop == 2'd0) q_in[0] = s1_out;
         else                         q_in[1] = s1_out;
         count_in = count_after_pop + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= 2'd0;
      else       count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   // ---------------------------------------------------------------------------------
   // request acceptance: store ready, room for the response, and no same-entry
   // request one stage ahead (its write-back value is not ready in time)
   // ---------------------------------------------------------------------------------
   logic hazard;
   logic room;

   assign hazard    = s1_valid_ff && (s1_addr_ff == cur_addr);
   assign room      = (count_after_pop + {1'b0, s1_valid_ff}) < 2'd2;
   assign req_ready = !clr_busy_ff && !hazard && room;

   // ---------------------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------------------
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("response queue overflow");

   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_fire)
      else $error("request accepted during store clearing");

   a_no_adjacent_alias: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff) |-> (s1_addr_ff != s2_addr_ff))
      else $error("back-to-back requests on the same store entry");

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> rsp_valid)
      else $error("response lost after store read");

   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !s3_valid_ff)
      else $error("write-back during store clearing");

endmodule

FILE: verif/feedback_comb_reverb_top_tb.sv
// feedback_comb_reverb_top_tb: self-checking bench for the feedback comb reverb top level
// depends on fcr_pkg and feedback_comb_reverb_top; runs directed then random request streams
// against a bit-exact comb filter predictor, with bursty requests and a stalling receiver
`timescale 1ns / 100ps

module feedback_comb_reverb_top_tb;
   import fcr_pkg::*;

   // index that maps to no register, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   localparam int RANDOM_ITEMS = 2000;
   localparam int SETTLE_CYCLES = 4;        // response latency plus margin
   localparam int TIMEOUT_NS = 12 * 400000;

   localparam logic signed [39:0] ENTRY_HI = 40'sd2097151;
   localparam logic signed [39:0] ENTRY_LO = -40'sd2097152;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_ready;
   sample_type req_sample_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   sample_type rsp_sample_out;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   feedback_comb_reverb_top uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------
   // shadow of the comb filter: registers, delay line and position
   // ---------------------------------------------------------------
   logic [DELAY_W-1:0] shadow_delay = DELAY_RESET;
   logic [GAIN_W-1:0] shadow_gain = GAIN_RESET;
   logic [CHCNT_W-1:0] shadow_chans = CHCNT_RESET;
   entry_type echo_line [0:STORE_DEPTH-1];
   logic [SLOT_W-1:0] echo_slot = '0;
   logic [CHAN_W-1:0] echo_chan = '0;

   sample_type sample_backlog [$];   // requests not yet offered to the block
   sample_type echo_due [$];         // predicted responses, oldest first
   int fail_count = 0;

   // run one sample through the comb: read the tap, sum, damp, write back, advance
   function automatic sample_type comb_step(sample_type x);
      int addr;
      int delay_eff;
      int chans_eff;
      logic signed [Y5_W-1:0] sum_q5;
      logic signed [39:0] damped;
      logic signed [Y5_W-1:0] whole;
      addr = int'(echo_slot) * MAX_CHANNELS + int'(echo_chan);
      // x + entry/2 held exactly with five fraction bits
      sum_q5 = x * 23'sd32 + echo_line[addr];
      // q1.15 damping, truncate toward zero back to q.4, then saturate
      damped = sum_q5 * $signed({1'b0, shadow_gain});
      damped = damped / 40'sd65536;
      if (damped > ENTRY_HI) damped = ENTRY_HI;
      if (damped < ENTRY_LO) damped = ENTRY_LO;
      echo_line[addr] = damped[STORE_W-1:0];
      // output: drop the fraction toward zero and clamp to 16 bits
      whole = sum_q5 / 23'sd32;
      if (whole > 23'sd32767) whole = 23'sd32767;
      if (whole < -23'sd32768) whole = -23'sd32768;
      // zero delay or channel count acts as one, oversized values saturate
      delay_eff = (shadow_delay == '0) ? 1 :
                  (int'(shadow_delay) > MAX_DELAY_FRAMES) ? MAX_DELAY_FRAMES :
                  int'(shadow_delay);
      chans_eff = (shadow_chans == '0) ? 1 :
                  (int'(shadow_chans) > MAX_CHANNELS) ? MAX_CHANNELS :
                  int'(shadow_chans);
      // lowered channel count ends the frame; shortened delay wraps the slot
      if (int'(echo_chan) + 1 >= chans_eff) begin
         echo_chan = '0;
         if (int'(echo_slot) + 1 >= delay_eff) begin
            echo_slot = '0;
         end else begin
            echo_slot = echo_slot + 1'b1;
         end
      end else begin
         echo_chan = echo_chan + 1'b1;
      end
      return whole[SAMPLE_W-1:0];
   endfunction

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endfunction

   // ---------------------------------------------------------------
   // monitor: predict on each accepted request, check each response
   // ---------------------------------------------------------------
   logic req_taken = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (echo_due.size() == 0) begin
               note_failure($sformatf("unexpected response, sample_out %0d", rsp_sample_out));
            end else if (rsp_sample_out !== echo_due[0]) begin
               note_failure($sformatf("sample_out mismatch: expected %0d, got %0d",
                                      echo_due[0], rsp_sample_out));
               void'(echo_due.pop_front());
            end else begin
               void'(echo_due.pop_front());
            end
         end
         if (req_valid && req_ready) echo_due.push_back(comb_step(req_sample_in));
      end
   end

   // ---------------------------------------------------------------
   // driver: bursts of requests from the backlog with random gaps
   // ---------------------------------------------------------------
   int burst_left = 1;
   int gap_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         // slot is free: either idle or the last request just went in
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (sample_backlog.size() > 0) begin
            req_valid <= 1'b1;
            req_sample_in <= sample_backlog.pop_front();
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver: ready pattern that switches mode every so often
   // ---------------------------------------------------------------
   rx_mode_type rx_mode = RX_OPEN;
   int rx_left = 0;
   int rx_tick = 0;

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(50, 300);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
         RX_OPEN: begin
            rsp_ready <= 1'b1;
         end
         RX_COIN: begin
            rsp_ready <= $urandom_range(0, 1);
         end
         RX_SPARSE: begin
            rsp_ready <= (rx_tick % 4 == 0);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 7) != 0);
         end
      endcase
   end

   // ---------------------------------------------------------------
   // register writes, only between phases while nothing is in flight
   // ---------------------------------------------------------------
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_DELAY_FRAMES: begin
            shadow_delay = data[DELAY_W-1:0];
         end
         CSR_DAMPING_GAIN: begin
            shadow_gain = data[GAIN_W-1:0];
         end
         CSR_CHANNEL_COUNT: begin
            shadow_chans = data[CHCNT_W-1:0];
         end
         default: begin
         end
      endcase
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // sender holds off until every predicted response is back, then settles
   task automatic wait_idle();
      do @(posedge clock);
      while (sample_backlog.size() != 0 || req_valid || echo_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

   // ---------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------
   initial begin
      int issued;
      int n;
      int pick;
      logic [DELAY_W-1:0] dl;
      sample_type s;
      for (int i = 0; i < STORE_DEPTH; i++) echo_line[i] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: extremes and the values around zero
      sample_backlog = '{16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh0000, -16'sh0001,
                         16'sh0001};
      wait_idle();

      // zero delay and zero channels act as one; gain above unity drives
      // the store into saturation both ways
      write_reg(CSR_DAMPING_GAIN, 16'hffff);
      write_reg(CSR_DELAY_FRAMES, 16'h0000);
      write_reg(CSR_CHANNEL_COUNT, 16'h0000);
      end_writes();
      repeat (5) sample_backlog.push_back(16'sh7fff);
      repeat (5) sample_backlog.push_back(-16'sh8000);
      wait_idle();

      // oversized delay and channel count saturate; odd count leaves a frame open
      write_reg(CSR_DELAY_FRAMES, 16'hffff);
      write_reg(CSR_CHANNEL_COUNT, 16'h0003);
      write_reg(CSR_DAMPING_GAIN, 16'h8000);
      end_writes();
      sample_backlog = '{16'sh1234, -16'sh4321, 16'sh7fff, -16'sh8000, 16'sh00ff};
      wait_idle();

      // channel count lowered mid frame and delay shortened below the slot;
      // the spare index must change nothing
      write_reg(CSR_DELAY_FRAMES, 16'h0002);
      write_reg(CSR_CHANNEL_COUNT, 16'h0001);
      write_reg(CSR_DAMPING_GAIN, 16'h0000);
      write_reg(CSR_SPARE, 16'hffff);
      end_writes();
      sample_backlog = '{16'sh5555, -16'sh2aab, 16'sh0100};
      wait_idle();

      // random phases, each with its own mix of settings
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0: dl = '0;
               1: dl = DELAY_MAX;
               2: dl = '1;
               3: dl = DELAY_W'($urandom_range(1, 16383));
               default: dl = DELAY_W'($urandom_range(1, 48));
            endcase
            write_reg(CSR_DELAY_FRAMES, {2'($urandom), dl});
         end
         if ($urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 5);
            case (pick)
               0: write_reg(CSR_DAMPING_GAIN, 16'h0000);
               1: write_reg(CSR_DAMPING_GAIN, 16'h8000);
               2: write_reg(CSR_DAMPING_GAIN, 16'hffff);
               default: write_reg(CSR_DAMPING_GAIN, 16'($urandom));
            endcase
         end
         if ($urandom_range(0, 2) != 0) begin
            write_reg(CSR_CHANNEL_COUNT, {14'($urandom), 2'($urandom)});
         end
         if ($urandom_range(0, 7) == 0) write_reg(CSR_SPARE, 16'($urandom));
         end_writes();

         // long delays never wrap within a phase, so keep those phases short
         n = (int'(shadow_delay) > 64) ? $urandom_range(10, 40) : $urandom_range(30, 160);
         for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               s = sample_type'($urandom);
            end else if (pick < 8) begin
               s = sample_type'($urandom_range(0, 2047) - 1024);
            end else begin
               case ($urandom_range(0, 3))
                  0: s = 16'sh7fff;
                  1: s = -16'sh8000;
                  2: s = 16'sh7fff - sample_type'($urandom_range(0, 15));
                  default: s = -16'sh8000 + sample_type'($urandom_range(0, 15));
               endcase
            end
            sample_backlog.push_back(s);
         end
         issued += n;
         wait_idle();
      end

      // drained; give any stray response time to show up
      repeat (8) @(posedge clock);
      if (echo_due.size() != 0) begin
         note_failure($sformatf("%0d responses never arrived", echo_due.size()));
      end
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
